// ===== sv/dtd_pkg.sv =====
// Package for the Gregorian date-time difference unit.
// Holds the shared types, calendar tables and constants; no dependencies.
package dtd_pkg;

    // Field widths of one timestamp.
    localparam int DayW    = 5;
    localparam int MonthW  = 4;
    localparam int YearW   = 14;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;

    // Width of a day count or a day difference.
    localparam int DaysW = 22;

    // Calendar limits.
    localparam int MaxYear   = 9999;
    localparam int MaxHour   = 23;
    localparam int MaxMinute = 59;
    localparam int MaxSecond = 59;
    localparam int SecPerMin = 60;
    localparam int MinPerHr  = 60;
    localparam int HrPerDay  = 24;
    localparam int DaysPerYr = 365;

    // Division by 100 as a multiplication by a reciprocal: floor(y / 100) equals
    // (y * Recip100) >> Recip100Shift for every 14-bit year.
    localparam int Recip100      = 5243;
    localparam int Recip100Shift = 19;
    localparam int ProdW         = YearW + 13;
    localparam int CentW         = ProdW - Recip100Shift;

    // Stage enables of the timestamp pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // One timestamp reduced to a day count and a time of day.
    typedef struct packed {
        logic               ok;
        logic [DaysW-1:0]   days;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } stamp_t;

    // Length of a month; February follows the leap flag.
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] mo,
                                                  input logic leap);
        logic [DayW-1:0] len;
        begin
            case (mo)
                4'd2:                       len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7,
                4'd8, 4'd10, 4'd12:         len = 5'd31;
                default:                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Days of the months before the given month, in a common year.
    function automatic logic [8:0] days_before(input logic [MonthW-1:0] mo);
        logic [8:0] n;
        begin
            case (mo)
                4'd1:    n = 9'd0;
                4'd2:    n = 9'd31;
                4'd3:    n = 9'd59;
                4'd4:    n = 9'd90;
                4'd5:    n = 9'd120;
                4'd6:    n = 9'd151;
                4'd7:    n = 9'd181;
                4'd8:    n = 9'd212;
                4'd9:    n = 9'd243;
                4'd10:   n = 9'd273;
                4'd11:   n = 9'd304;
                4'd12:   n = 9'd334;
                default: n = 9'd0;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== sv/dtd_stamp.sv =====
// Three-stage pipeline that checks one timestamp and converts it to a day count.
// Depends on dtd_pkg for the calendar tables and the stamp_t result type.
module dtd_stamp (
    input  logic                          aclk,
    input  dtd_pkg::stage_en_t            en,
    input  logic [dtd_pkg::DayW-1:0]      day,
    input  logic [dtd_pkg::MonthW-1:0]    month,
    input  logic [dtd_pkg::YearW-1:0]     year,
    input  logic [dtd_pkg::HourW-1:0]     hour,
    input  logic [dtd_pkg::MinuteW-1:0]   minute,
    input  logic [dtd_pkg::SecondW-1:0]   second,
    output dtd_pkg::stamp_t               stamp
);
    import dtd_pkg::*;

    // Stage 1 registers.
    logic [YearW-1:0]   y1_reg;
    logic [ProdW-1:0]   prod1_reg;
    logic [22:0]        y365_1_reg;
    logic [MonthW-1:0]  mo1_reg;
    logic [DayW-1:0]    d1_reg;
    logic [HourW-1:0]   h1_reg;
    logic [MinuteW-1:0] mi1_reg;
    logic [SecondW-1:0] s1_reg;
    logic               ok1_reg;
    logic               ok1_next;

    // Stage 2 registers.
    logic [22:0]        base2_reg;
    logic [22:0]        base2_next;
    logic [CentW:0]     cent2_reg;
    logic [CentW:0]     cent2_next;
    logic               adj2_reg;
    logic               ok2_reg;
    logic               ok2_next;
    logic [HourW-1:0]   h2_reg;
    logic [MinuteW-1:0] mi2_reg;
    logic [SecondW-1:0] s2_reg;

    // Stage 2 helpers.
    logic [CentW-1:0]   q2;
    logic [YearW-1:0]   hundreds2;
    logic               rem_nz2;
    logic               leap2;
    logic [YearW:0]     quarter2;

    // Stage 3.
    stamp_t             stamp_reg;
    stamp_t             stamp_next;
    logic [CentW:0]     quad3;

    // Range checks that need no day count.
    assign ok1_next = (month >= 4'd1) && (month <= 4'd12) &&
                      (year <= YearW'(MaxYear)) && (hour <= HourW'(MaxHour)) &&
                      (minute <= MinuteW'(MaxMinute)) && (second <= SecondW'(MaxSecond));

    // Stage 1: the two constant multiplications.
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            y1_reg     <= year;
            prod1_reg  <= ProdW'(year) * ProdW'(Recip100);
            y365_1_reg <= 23'(year) * 23'(DaysPerYr);
            mo1_reg    <= month;
            d1_reg     <= day;
            h1_reg     <= hour;
            mi1_reg    <= minute;
            s1_reg     <= second;
            ok1_reg    <= ok1_next;
        end
    end

    // Stage 2: century count, leap rule, day check and the partial day count.
    assign q2        = prod1_reg[ProdW-1:Recip100Shift];
    assign hundreds2 = YearW'(YearW'(q2) * YearW'(100));
    assign rem_nz2   = (y1_reg != hundreds2);
    assign leap2     = rem_nz2 ? (y1_reg[1:0] == 2'd0) : (q2[1:0] == 2'd0);
    assign quarter2  = (YearW+1)'(y1_reg) + (YearW+1)'(3);
    assign cent2_next = (CentW+1)'(q2) + (CentW+1)'(rem_nz2);
    assign base2_next = y365_1_reg + 23'(quarter2[YearW:2]) + 23'(days_before(mo1_reg))
                      + 23'(d1_reg);
    assign ok2_next  = ok1_reg && (d1_reg != 5'd0) && (d1_reg <= month_len(mo1_reg, leap2));

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            base2_reg <= base2_next;
            cent2_reg <= cent2_next;
            adj2_reg  <= (mo1_reg > 4'd2) && leap2;
            ok2_reg   <= ok2_next;
            h2_reg    <= h1_reg;
            mi2_reg   <= mi1_reg;
            s2_reg    <= s1_reg;
        end
    end

    // Stage 3: drop the century years and add back every fourth century.
    assign quad3 = cent2_reg + (CentW+1)'(3);
    always_comb begin
        stamp_next.ok     = ok2_reg;
        stamp_next.days   = DaysW'(base2_reg - 23'(cent2_reg) + 23'(quad3[CentW:2])
                                   + 23'(adj2_reg));
        stamp_next.hour   = h2_reg;
        stamp_next.minute = mi2_reg;
        stamp_next.second = s2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            stamp_reg <= stamp_next;
        end
    end

    assign stamp = stamp_reg;

endmodule

// ===== sv/dtd_diff.sv =====
// Two-stage pipeline that orders two converted timestamps and subtracts them
// digit by digit in mixed radix. Depends on dtd_pkg for stamp_t.
module dtd_diff (
    input  logic                          aclk,
    input  logic                          en_order,
    input  logic                          en_sub,
    input  dtd_pkg::stamp_t               stamp_a,
    input  dtd_pkg::stamp_t               stamp_b,
    output logic                          ok,
    output logic [dtd_pkg::DaysW-1:0]     diff_days,
    output logic [dtd_pkg::HourW-1:0]     diff_hours,
    output logic [dtd_pkg::MinuteW-1:0]   diff_minutes,
    output logic [dtd_pkg::SecondW-1:0]   diff_seconds
);
    import dtd_pkg::*;

    localparam int TimeW = DaysW + HourW + MinuteW + SecondW;

    stamp_t             big_reg;
    stamp_t             small_reg;
    logic               ok4_reg;
    logic               a_ge_b;

    logic [SecondW:0]   sec_d;
    logic [MinuteW:0]   min_d;
    logic [HourW:0]     hr_d;
    logic               bor_s;
    logic               bor_m;
    logic               bor_h;

    logic               ok_reg;
    logic [DaysW-1:0]   days_reg;
    logic [DaysW-1:0]   days_next;
    logic [HourW-1:0]   hours_reg;
    logic [HourW-1:0]   hours_next;
    logic [MinuteW-1:0] minutes_reg;
    logic [MinuteW-1:0] minutes_next;
    logic [SecondW-1:0] seconds_reg;
    logic [SecondW-1:0] seconds_next;

    // Field ranges are checked, so comparing the packed fields compares the times.
    assign a_ge_b = TimeW'({stamp_a.days, stamp_a.hour, stamp_a.minute, stamp_a.second}) >=
                    TimeW'({stamp_b.days, stamp_b.hour, stamp_b.minute, stamp_b.second});

    // Stage 4: put the later timestamp first.
    always_ff @(posedge aclk) begin
        if (en_order) begin
            big_reg   <= a_ge_b ? stamp_a : stamp_b;
            small_reg <= a_ge_b ? stamp_b : stamp_a;
            ok4_reg   <= stamp_a.ok && stamp_b.ok;
        end
    end

    // Borrow chain from seconds up to days.
    assign sec_d = (SecondW+1)'(big_reg.second) - (SecondW+1)'(small_reg.second);
    assign bor_s = sec_d[SecondW];
    assign min_d = (MinuteW+1)'(big_reg.minute) - (MinuteW+1)'(small_reg.minute)
                 - (MinuteW+1)'(bor_s);
    assign bor_m = min_d[MinuteW];
    assign hr_d  = (HourW+1)'(big_reg.hour) - (HourW+1)'(small_reg.hour)
                 - (HourW+1)'(bor_m);
    assign bor_h = hr_d[HourW];

    always_comb begin
        seconds_next = bor_s ? SecondW'(sec_d + (SecondW+1)'(SecPerMin)) : SecondW'(sec_d);
        minutes_next = bor_m ? MinuteW'(min_d + (MinuteW+1)'(MinPerHr)) : MinuteW'(min_d);
        hours_next   = bor_h ? HourW'(hr_d + (HourW+1)'(HrPerDay)) : HourW'(hr_d);
        days_next    = big_reg.days - small_reg.days - DaysW'(bor_h);
        // An invalid pair reports all zeros.
        if (!ok4_reg) begin
            seconds_next = '0;
            minutes_next = '0;
            hours_next   = '0;
            days_next    = '0;
        end
    end

    // Stage 5: result register.
    always_ff @(posedge aclk) begin
        if (en_sub) begin
            ok_reg      <= ok4_reg;
            days_reg    <= days_next;
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
        end
    end

    assign ok           = ok_reg;
    assign diff_days    = days_reg;
    assign diff_hours   = hours_reg;
    assign diff_minutes = minutes_reg;
    assign diff_seconds = seconds_reg;

endmodule

// ===== sv/gregorian_datetime_difference_unit.sv =====
// Top level of the Gregorian date-time difference unit: stream ports, pipeline
// valid/ready control, two timestamp pipelines and the difference stages.
// Depends on dtd_pkg, dtd_stamp and dtd_diff.
//
//   Channel  Direction  Data                                   Side band
//   s_       in         tdata: timestamp a, timestamp b (80b)  none
//   m_       out        tdata: day/hour/min/sec difference     tuser: valid_res
//
// Five register stages: three convert each timestamp to a day count, one orders
// the pair, one subtracts with borrows and holds the result. One request is
// taken every cycle while m_ is not stalled.
// A stall on m_ fills the empty stages first; each stage holds while the one
// after it is full and not moving, so nothing is dropped or repeated.
// aresetn (synchronous, active low) clears the stage valid bits only.
module gregorian_datetime_difference_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // day_a[4:0] month_a[8:5] year_a[22:9] hour_a[27:23] minute_a[33:28]
    // second_a[39:34] day_b[44:40] month_b[48:45] year_b[62:49] hour_b[67:63]
    // minute_b[73:68] second_b[79:74]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // diff_days[21:0] diff_hours[26:22] diff_minutes[32:27] diff_seconds[38:33],
    // bit 39 zero
    output logic [39:0] m_tdata,
    // valid_res[0]
    output logic [0:0]  m_tuser
);
    import dtd_pkg::*;

    localparam int Stages = 5;

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] vld_next;
    logic [Stages-1:0] rdy;

    stage_en_t         en;
    stamp_t            stamp_a;
    stamp_t            stamp_b;

    logic               res_ok;
    logic [DaysW-1:0]   res_days;
    logic [HourW-1:0]   res_hours;
    logic [MinuteW-1:0] res_minutes;
    logic [SecondW-1:0] res_seconds;

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        rdy[Stages-1] = !vld_reg[Stages-1] || m_tready;
        for (int i = Stages-2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        for (int i = 0; i < Stages; i++) begin
            if (rdy[i]) begin
                vld_next[i] = (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i-1];
            end else begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign en.s1    = rdy[0];
    assign en.s2    = rdy[1];
    assign en.s3    = rdy[2];
    assign s_tready = rdy[0];

    // Timestamp pipelines.
    dtd_stamp u_stamp_a (
        .aclk   (aclk),
        .en     (en),
        .day    (s_tdata[4:0]),
        .month  (s_tdata[8:5]),
        .year   (s_tdata[22:9]),
        .hour   (s_tdata[27:23]),
        .minute (s_tdata[33:28]),
        .second (s_tdata[39:34]),
        .stamp  (stamp_a)
    );

    dtd_stamp u_stamp_b (
        .aclk   (aclk),
        .en     (en),
        .day    (s_tdata[44:40]),
        .month  (s_tdata[48:45]),
        .year   (s_tdata[62:49]),
        .hour   (s_tdata[67:63]),
        .minute (s_tdata[73:68]),
        .second (s_tdata[79:74]),
        .stamp  (stamp_b)
    );

    // Ordering and subtraction.
    dtd_diff u_diff (
        .aclk         (aclk),
        .en_order     (rdy[3]),
        .en_sub       (rdy[4]),
        .stamp_a      (stamp_a),
        .stamp_b      (stamp_b),
        .ok           (res_ok),
        .diff_days    (res_days),
        .diff_hours   (res_hours),
        .diff_minutes (res_minutes),
        .diff_seconds (res_seconds)
    );

    assign m_tvalid = vld_reg[Stages-1];
    assign m_tdata  = {1'b0, res_seconds, res_minutes, res_hours, res_days};
    assign m_tuser  = res_ok;

endmodule

// ===== sv/dtd_checker.sv =====
// Port-level checker for the Gregorian date-time difference unit, bound to the
// top level. Depends only on the top level's ports.
module dtd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset leaves no result offered.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // The input is only held off while a result waits on the output.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with the output free");

    // An invalid pair reports zero difference.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 40'd0)
        else $error("invalid pair with nonzero difference");

    // Remainder fields stay inside their ranges.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[26:22] <= 5'd23 && m_tdata[32:27] <= 6'd59 &&
                     m_tdata[38:33] <= 6'd59 && !m_tdata[39])
        else $error("difference field out of range");

endmodule

bind gregorian_datetime_difference_unit dtd_checker u_dtd_checker (.*);
